### sv/i2cm_pkg.sv
// Shared types and command codes for the I2C master bit engine.
package i2cm_pkg;

    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_WRITE = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;
    localparam logic [2:0] FUNC_ACK   = 3'd5;
    localparam logic [2:0] FUNC_NACK  = 3'd6;
    localparam logic [2:0] FUNC_WAIT  = 3'd7;

    localparam int                QUEUE_DEPTH = 2;
    localparam int                PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int                CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam logic [9:0]        LIMIT_RESET = 10'd255;

    typedef struct packed {
        logic       is_cmd;
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       sda_in;
    } item_t;

endpackage

### sv/i2cm_front.sv
// Front end: accepts input transactions and classifies them for the queue.
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] func,
    input  logic [7:0] tx_byte,
    input  logic       sda_in,
    input  logic       q_full,
    output logic       push,
    output item_t      push_item
);

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_item.is_cmd  = (func != FUNC_TICK);
        push_item.func    = func;
        push_item.tx_byte = tx_byte;
        push_item.sda_in  = sda_in;
    end

endmodule

### sv/i2cm_queue.sv
// Short queue between the front end and the bit sequencer.
module i2cm_queue
    import i2cm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  not_empty,
    output item_t head
);

    item_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### sv/i2cm_back.sv
// Bit sequencer: runs the SCL/SDA phase pattern and registers each result.
module i2cm_back
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [9:0] cfg_wr_data,
    input  logic       q_not_empty,
    input  item_t      q_head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_level,
    output logic       sda_level,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] rx_byte,
    output logic       ack_failed
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_START = 3'd1,
        ST_STOP  = 3'd2,
        ST_WRITE = 3'd3,
        ST_READ  = 3'd4,
        ST_ACK   = 3'd5,
        ST_NACK  = 3'd6,
        ST_WAIT  = 3'd7
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] phase_reg, phase_next;
    logic [3:0] bitc_reg, bitc_next;
    logic [7:0] shifter_reg, shifter_next;
    logic [9:0] timeout_reg, timeout_next;
    logic [9:0] limit_reg;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       fail_reg, fail_next;
    logic [7:0] rx_reg, rx_next;
    logic       done_next;
    logic       out_valid_reg, out_valid_next;
    logic       busy_out_reg;
    logic       done_out_reg;

    // A result slot is free when empty or being taken this cycle.
    assign pop = q_not_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        bitc_next    = bitc_reg;
        shifter_next = shifter_reg;
        timeout_next = timeout_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        fail_next    = fail_reg;
        rx_next      = rx_reg;
        done_next    = 1'b0;

        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (q_head.is_cmd)
                begin
                    state_next = state_t'(q_head.func);
                    phase_next = 5'd1;
                    bitc_next  = 4'd0;
                    unique case (q_head.func) inside
                        FUNC_START:
                        begin
                            scl_next = 1'b0;
                            sda_next = 1'b1;
                        end
                        FUNC_STOP:
                        begin
                            scl_next = 1'b0;
                            sda_next = 1'b0;
                        end
                        FUNC_WRITE:
                        begin
                            scl_next     = 1'b0;
                            sda_next     = q_head.tx_byte[7];
                            shifter_next = {q_head.tx_byte[6:0], 1'b0};
                            bitc_next    = 4'd1;
                        end
                        FUNC_READ:
                        begin
                            scl_next     = 1'b0;
                            shifter_next = '0;
                        end
                        FUNC_ACK, FUNC_NACK:
                        begin
                            scl_next = 1'b0;
                        end
                        default:
                        begin
                            sda_next     = 1'b1;
                            timeout_next = '0;
                        end
                    endcase
                end
            end
            ST_START:
            begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 5'd1)
                begin
                    scl_next = 1'b1;
                end
                else if (phase_reg == 5'd2)
                begin
                    sda_next = 1'b0;
                end
                else
                begin
                    scl_next   = 1'b0;
                    state_next = ST_IDLE;
                    phase_next = '0;
                    done_next  = 1'b1;
                end
            end
            ST_STOP:
            begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 5'd1)
                begin
                    scl_next = 1'b1;
                end
                else if (phase_reg == 5'd2)
                begin
                    sda_next = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                    phase_next = '0;
                    done_next  = 1'b1;
                end
            end
            ST_WRITE:
            begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg >= 5'd16)
                begin
                    scl_next   = 1'b0;
                    state_next = ST_IDLE;
                    phase_next = '0;
                    done_next  = 1'b1;
                end
                else if (phase_reg[0])
                begin
                    scl_next = 1'b1;
                end
                else
                begin
                    scl_next     = 1'b0;
                    sda_next     = shifter_reg[7];
                    shifter_next = {shifter_reg[6:0], 1'b0};
                    bitc_next    = bitc_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg >= 5'd16)
                begin
                    rx_next    = shifter_reg;
                    state_next = ST_IDLE;
                    phase_next = '0;
                    done_next  = 1'b1;
                end
                else if (phase_reg[0])
                begin
                    scl_next     = 1'b1;
                    shifter_next = {shifter_reg[6:0], q_head.sda_in};
                    bitc_next    = bitc_reg + 1'b1;
                end
                else
                begin
                    scl_next = 1'b0;
                end
            end
            ST_ACK, ST_NACK:
            begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 5'd1)
                begin
                    sda_next = (state_reg == ST_NACK);
                end
                else if (phase_reg == 5'd2)
                begin
                    scl_next = 1'b1;
                end
                else
                begin
                    scl_next   = 1'b0;
                    state_next = ST_IDLE;
                    phase_next = '0;
                    done_next  = 1'b1;
                end
            end
            ST_WAIT:
            begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 5'd1)
                begin
                    scl_next = 1'b1;
                end
                else if (phase_reg == 5'd2)
                begin
                    if (!q_head.sda_in)
                    begin
                        scl_next   = 1'b0;
                        fail_next  = 1'b0;
                        state_next = ST_IDLE;
                        phase_next = '0;
                        done_next  = 1'b1;
                    end
                    else if (timeout_reg >= limit_reg)
                    begin
                        // Timed out: fall into the stop sequence.
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                    end
                    else
                    begin
                        timeout_next = timeout_reg + 1'b1;
                        phase_next   = phase_reg;
                    end
                end
                else if (phase_reg == 5'd3)
                begin
                    scl_next = 1'b1;
                end
                else if (phase_reg == 5'd4)
                begin
                    sda_next = 1'b1;
                end
                else
                begin
                    fail_next  = 1'b1;
                    state_next = ST_IDLE;
                    phase_next = '0;
                    done_next  = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            bitc_reg      <= '0;
            shifter_reg   <= '0;
            timeout_reg   <= '0;
            limit_reg     <= LIMIT_RESET;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            fail_reg      <= 1'b0;
            rx_reg        <= '0;
            out_valid_reg <= 1'b0;
            busy_out_reg  <= 1'b0;
            done_out_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (pop)
            begin
                state_reg    <= state_next;
                phase_reg    <= phase_next;
                bitc_reg     <= bitc_next;
                shifter_reg  <= shifter_next;
                timeout_reg  <= timeout_next;
                scl_reg      <= scl_next;
                sda_reg      <= sda_next;
                fail_reg     <= fail_next;
                rx_reg       <= rx_next;
                busy_out_reg <= (state_next != ST_IDLE);
                done_out_reg <= done_next;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign scl_level  = scl_reg;
    assign sda_level  = sda_reg;
    assign busy_res   = busy_out_reg;
    assign done_res   = done_out_reg;
    assign rx_byte    = rx_reg;
    assign ack_failed = fail_reg;

endmodule

### sv/i2c_master_bit_engine.sv
// I2C master bit engine: takes one transaction per clock while in_stall is low, each a
// command or a line-phase tick, and returns one result transaction for each, showing the
// SCL/SDA levels, busy, done, the last received byte and the ack failure flag. The sustained
// rate is one transaction per cycle while out_stall is low, set by the bit sequencer, which
// performs one phase update per transaction. An accepted input waits in the queue until the
// sequencer takes it and registers its result. A two-entry queue lets the input side accept
// two more transactions while a result is held by a stalled consumer before it stalls in
// turn. The ack timeout limit resets to 255 and is written through the configuration port
// while the engine is idle; the user must keep to this, as the block does not enforce it.
module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [9:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] func,
    input  logic [7:0] tx_byte,
    input  logic       sda_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_level,
    output logic       sda_level,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] rx_byte,
    output logic       ack_failed
);

    logic  push;
    item_t push_item;
    logic  q_full;
    logic  q_not_empty;
    logic  pop;
    item_t q_head;

    i2cm_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .tx_byte   (tx_byte),
        .sda_in    (sda_in),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    i2cm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    i2cm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .scl_level   (scl_level),
        .sda_level   (sda_level),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .rx_byte     (rx_byte),
        .ack_failed  (ack_failed)
    );

endmodule

### sv/i2cm_checker.sv
// Port-level checks for the I2C master bit engine, bound to the top level.
module i2cm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_wr_en,
    input logic [9:0] cfg_wr_data,
    input logic       in_valid,
    input logic       in_stall,
    input logic [2:0] func,
    input logic [7:0] tx_byte,
    input logic       sda_in,
    input logic       out_valid,
    input logic       out_stall,
    input logic       scl_level,
    input logic       sda_level,
    input logic       busy_res,
    input logic       done_res,
    input logic [7:0] rx_byte,
    input logic       ack_failed
);

    // A stalled result must stay put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(scl_level) && $stable(sda_level)
            && $stable(busy_res) && $stable(done_res) && $stable(rx_byte))
        else $error("result changed while stalled");

    // A completing step leaves the engine idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(done_res && busy_res))
        else $error("done reported while still busy");

    // The failure flag only moves when a command completes.
    a_fail_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ack_failed != $past(ack_failed)) |-> done_res)
        else $error("ack_failed changed without a completion");

    // The received byte only moves when a command completes.
    a_rx_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (rx_byte != $past(rx_byte)) |-> done_res)
        else $error("rx_byte changed without a completion");

endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (.*);
